// File: sv/nnae_pkg.sv
// nnae_pkg: shared types and constants for the network accumulator evaluator.
// Holds opcodes, sequencer states, lane unit control and field widths.
// No dependencies.
package nnae_pkg;

    localparam int DEF_FEATURES = 768;
    localparam int DEF_HIDDEN   = 256;

    localparam int OP_W       = 3;
    localparam int FEAT_W     = 10;
    localparam int NEUR_W     = 8;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 32;
    localparam int HIU_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int OUT_DIVISOR = 64 * 256;
    localparam int DIV_SHIFT   = $clog2(OUT_DIVISOR);
    localparam int SCORE_W     = SUM_W - DIV_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BIAS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_IN_USE = 1'd1;

    localparam logic [HIU_W-1:0] HIU_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_IN_W  = 3'd0,
        OP_LOAD_BIAS  = 3'd1,
        OP_LOAD_OUT_W = 3'd2,
        OP_INIT       = 3'd3,
        OP_ADD        = 3'd4,
        OP_SUB        = 3'd5,
        OP_EVAL       = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        LM_COPY,
        LM_ADD,
        LM_SUB
    } t_lane_mode;

    typedef struct packed {
        t_lane_mode mode;
        logic       sum_load;
        logic       prod_en;
        logic       mac_en;
    } t_unit_ctl;

endpackage

// File: sv/nnae_store.sv
// nnae_store: input weight, bias, output weight and accumulator memories.
// One write and one registered read port per memory; uses nnae_pkg.
module nnae_store import nnae_pkg::*; #(
    parameter int FEATURES = DEF_FEATURES,
    parameter int HIDDEN   = DEF_HIDDEN,
    localparam int LW      = (HIDDEN > 1) ? $clog2(HIDDEN) : 1,
    localparam int FDEPTH  = FEATURES * HIDDEN,
    localparam int FAW     = (FDEPTH > 1) ? $clog2(FDEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_fw_we,
    input  logic [FAW-1:0]          i_fw_waddr,
    input  logic [FAW-1:0]          i_fw_raddr,
    input  logic                    i_nb_we,
    input  logic                    i_ow_we,
    input  logic [LW-1:0]           i_hw_waddr,
    input  logic [LW-1:0]           i_lane_raddr,
    input  logic                    i_acc_we,
    input  logic [LW-1:0]           i_acc_waddr,
    input  logic signed [VAL_W-1:0] i_acc_wdata,
    output logic signed [VAL_W-1:0] o_fw_rdata,
    output logic signed [VAL_W-1:0] o_nb_rdata,
    output logic signed [VAL_W-1:0] o_ow_rdata,
    output logic signed [VAL_W-1:0] o_acc_rdata
);

    logic [VAL_W-1:0] r_fw_mem  [FDEPTH];
    logic [VAL_W-1:0] r_nb_mem  [HIDDEN];
    logic [VAL_W-1:0] r_ow_mem  [HIDDEN];
    logic [VAL_W-1:0] r_acc_mem [HIDDEN];

    logic [VAL_W-1:0] r_fw_rd;
    logic [VAL_W-1:0] r_nb_rd;
    logic [VAL_W-1:0] r_ow_rd;
    logic [VAL_W-1:0] r_acc_rd;

    always_ff @(posedge i_clk) begin
        if (i_fw_we) begin
            r_fw_mem[i_fw_waddr] <= i_value;
        end
        r_fw_rd <= r_fw_mem[i_fw_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_nb_we) begin
            r_nb_mem[i_hw_waddr] <= i_value;
        end
        r_nb_rd <= r_nb_mem[i_lane_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ow_we) begin
            r_ow_mem[i_hw_waddr] <= i_value;
        end
        r_ow_rd <= r_ow_mem[i_lane_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_acc_we) begin
            r_acc_mem[i_acc_waddr] <= i_acc_wdata;
        end
        r_acc_rd <= r_acc_mem[i_lane_raddr];
    end

    assign o_fw_rdata  = r_fw_rd;
    assign o_nb_rdata  = r_nb_rd;
    assign o_ow_rdata  = r_ow_rd;
    assign o_acc_rdata = r_acc_rd;

endmodule

// File: sv/nnae_lane_unit.sv
// nnae_lane_unit: shared lane arithmetic (copy, add, subtract, ReLU multiply-accumulate).
// Registered product and output sum; uses nnae_pkg.
module nnae_lane_unit import nnae_pkg::*; (
    input  logic                    i_clk,
    input  t_unit_ctl               i_ctl,
    input  logic [SUM_W-1:0]        i_bias,
    input  logic signed [VAL_W-1:0] i_acc,
    input  logic signed [VAL_W-1:0] i_in_w,
    input  logic signed [VAL_W-1:0] i_nb,
    input  logic signed [VAL_W-1:0] i_ow,
    output logic signed [VAL_W-1:0] o_lane,
    output logic [SUM_W-1:0]        o_sum
);

    logic signed [VAL_W:0]     w_relu;
    logic signed [2*VAL_W:0]   w_prod;
    logic [SUM_W-1:0]          r_prod;
    logic [SUM_W-1:0]          r_sum;

    assign w_relu = i_acc[VAL_W-1] ? '0 : {1'b0, i_acc};
    assign w_prod = w_relu * i_ow;

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= w_prod[SUM_W-1:0];
        end
        if (i_ctl.sum_load) begin
            r_sum <= i_bias;
        end else if (i_ctl.mac_en) begin
            r_sum <= r_sum + r_prod;
        end
    end

    always_comb begin
        case (i_ctl.mode)
            LM_COPY: o_lane = i_nb;
            LM_SUB:  o_lane = i_acc - i_in_w;
            default: o_lane = i_acc + i_in_w;
        endcase
    end

    assign o_sum = r_sum;

endmodule

// File: sv/nnae_seq.sv
// nnae_seq: operation decode and lane sequencer.
// Drives memory addresses, write enables and lane unit control; uses nnae_pkg.
module nnae_seq import nnae_pkg::*; #(
    parameter int FEATURES = DEF_FEATURES,
    parameter int HIDDEN   = DEF_HIDDEN,
    localparam int LW      = (HIDDEN > 1) ? $clog2(HIDDEN) : 1,
    localparam int FDEPTH  = FEATURES * HIDDEN,
    localparam int FAW     = (FDEPTH > 1) ? $clog2(FDEPTH) : 1,
    localparam int CW      = $clog2(HIDDEN + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_op,
    input  logic [FEAT_W-1:0] i_feature,
    input  logic [NEUR_W-1:0] i_neuron,
    input  logic [HIU_W-1:0]  i_hidden_in_use,
    output logic              o_busy,
    output logic              o_fw_we,
    output logic              o_nb_we,
    output logic              o_ow_we,
    output logic [FAW-1:0]    o_fw_waddr,
    output logic [LW-1:0]     o_hw_waddr,
    output logic [FAW-1:0]    o_fw_raddr,
    output logic [LW-1:0]     o_lane_raddr,
    output logic              o_acc_we,
    output logic [LW-1:0]     o_acc_waddr,
    output t_unit_ctl         o_ctl,
    output logic              o_finish
);

    t_state          r_state;
    t_state          n_state;
    t_op             r_op;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_lane;
    logic [FAW-1:0]  r_faddr;
    logic            r_s1_valid;
    logic [LW-1:0]   r_s1_lane;
    logic            r_s2_valid;

    t_op             w_op;
    logic            w_accept;
    logic            w_feat_ok;
    logic            w_neur_ok;
    logic            w_run;
    logic [CW-1:0]   w_count;
    logic [FAW-1:0]  w_feat_base;
    logic            w_last;

    assign w_op        = t_op'(i_op);
    assign w_accept    = i_start && (r_state == ST_IDLE);
    assign w_feat_ok   = 32'(i_feature) < FEATURES;
    assign w_neur_ok   = 32'(i_neuron) < HIDDEN;
    assign w_count     = (32'(i_hidden_in_use) > HIDDEN) ? CW'(HIDDEN) : CW'(i_hidden_in_use);
    assign w_feat_base = FAW'(32'(i_feature) * HIDDEN);
    assign w_last      = (CW'(r_lane + 1'b1) == r_count);
    assign w_run       = w_accept && ((w_op == OP_INIT) || (w_op == OP_EVAL) ||
                         (((w_op == OP_ADD) || (w_op == OP_SUB)) && w_feat_ok));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_op       <= OP_LOAD_IN_W;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= (r_state == ST_ISSUE);
            r_s2_valid <= r_s1_valid && (r_op == OP_EVAL);
            if (w_run) begin
                r_op <= w_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lane <= r_lane[LW-1:0];
        if (w_run) begin
            r_count <= w_count;
            r_lane  <= '0;
            r_faddr <= w_feat_base;
        end else if (r_state == ST_ISSUE) begin
            r_lane  <= CW'(r_lane + 1'b1);
            r_faddr <= FAW'(r_faddr + 1'b1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_run) begin
                    n_state = (w_count == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) begin
                    n_state = (r_op == OP_EVAL) ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy       = (r_state != ST_IDLE);
        o_finish     = (r_state == ST_RESULT);
        o_fw_we      = w_accept && (w_op == OP_LOAD_IN_W) && w_feat_ok && w_neur_ok;
        o_nb_we      = w_accept && (w_op == OP_LOAD_BIAS) && w_neur_ok;
        o_ow_we      = w_accept && (w_op == OP_LOAD_OUT_W) && w_neur_ok;
        o_fw_waddr   = FAW'(32'(i_feature) * HIDDEN + 32'(i_neuron));
        o_hw_waddr   = LW'(i_neuron);
        o_fw_raddr   = r_faddr;
        o_lane_raddr = r_lane[LW-1:0];
        o_acc_we     = r_s1_valid && (r_op != OP_EVAL);
        o_acc_waddr  = r_s1_lane;
        o_ctl.sum_load = w_accept && (w_op == OP_EVAL);
        o_ctl.prod_en  = r_s1_valid && (r_op == OP_EVAL);
        o_ctl.mac_en   = r_s2_valid;
        case (r_op)
            OP_INIT: o_ctl.mode = LM_COPY;
            OP_SUB:  o_ctl.mode = LM_SUB;
            default: o_ctl.mode = LM_ADD;
        endcase
    end

endmodule

// File: sv/nnae_accumulator_eval_top_placeholder.sv
// nnae_accumulator_eval_top_placeholder: configuration register file for the evaluator.
// Holds the output bias and lane count; uses nnae_pkg.
module nnae_accumulator_eval_top_placeholder import nnae_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [SUM_W-1:0]      o_output_bias,
    output logic [HIU_W-1:0]      o_hidden_in_use
);

    logic [SUM_W-1:0] r_output_bias;
    logic [HIU_W-1:0] r_hidden_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_bias   <= '0;
            r_hidden_in_use <= HIU_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OUTPUT_BIAS:   r_output_bias   <= i_cfg_data[SUM_W-1:0];
                REG_HIDDEN_IN_USE: r_hidden_in_use <= i_cfg_data[HIU_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_output_bias   = r_output_bias;
    assign o_hidden_in_use = r_hidden_in_use;

endmodule

// File: sv/nn_accumulator_eval.sv
// nn_accumulator_eval: top level of the network accumulator evaluator.
// Instantiates the configuration registers, nnae_seq, nnae_store and nnae_lane_unit.
//
// Loads of a weight or bias leave busy low. Init, add and subtract issue each of the
// n lanes in use and then drain; evaluate does the same and then enters its result
// state, where n is the number of lanes in use (256 by default). With no lanes in use
// these operations go straight to the drain. One lane passes per cycle through the
// shared lane unit and the single read port of each memory. The score appears on
// o_score with o_valid high for exactly one cycle; the receiver cannot stall, so it
// must capture the transaction in that cycle. Results are not produced for any
// operation other than evaluate.
module nn_accumulator_eval import nnae_pkg::*; #(
    parameter int FEATURES = DEF_FEATURES,
    parameter int HIDDEN   = DEF_HIDDEN
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           i_op,
    input  logic [FEAT_W-1:0]         i_feature,
    input  logic [NEUR_W-1:0]         i_neuron,
    input  logic signed [VAL_W-1:0]   i_value,
    output logic                      o_valid,
    output logic signed [SCORE_W-1:0] o_score,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int LW     = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int FDEPTH = FEATURES * HIDDEN;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam logic [SUM_W-1:0] ROUND_ADJ = SUM_W'(OUT_DIVISOR - 1);

    logic [SUM_W-1:0]          w_output_bias;
    logic [HIU_W-1:0]          w_hidden_in_use;
    logic                      w_fw_we;
    logic                      w_nb_we;
    logic                      w_ow_we;
    logic [FAW-1:0]            w_fw_waddr;
    logic [LW-1:0]             w_hw_waddr;
    logic [FAW-1:0]            w_fw_raddr;
    logic [LW-1:0]             w_lane_raddr;
    logic                      w_acc_we;
    logic [LW-1:0]             w_acc_waddr;
    t_unit_ctl                 w_ctl;
    logic                      w_finish;
    logic signed [VAL_W-1:0]   w_fw_rdata;
    logic signed [VAL_W-1:0]   w_nb_rdata;
    logic signed [VAL_W-1:0]   w_ow_rdata;
    logic signed [VAL_W-1:0]   w_acc_rdata;
    logic signed [VAL_W-1:0]   w_lane;
    logic [SUM_W-1:0]          w_sum;
    logic [SUM_W-1:0]          w_adj;

    logic                      r_valid;
    logic [SCORE_W-1:0]        r_score;

    nnae_accumulator_eval_top_placeholder u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_output_bias   (w_output_bias),
        .o_hidden_in_use (w_hidden_in_use)
    );

    nnae_seq #(
        .FEATURES (FEATURES),
        .HIDDEN   (HIDDEN)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_op            (i_op),
        .i_feature       (i_feature),
        .i_neuron        (i_neuron),
        .i_hidden_in_use (w_hidden_in_use),
        .o_busy          (busy),
        .o_fw_we         (w_fw_we),
        .o_nb_we         (w_nb_we),
        .o_ow_we         (w_ow_we),
        .o_fw_waddr      (w_fw_waddr),
        .o_hw_waddr      (w_hw_waddr),
        .o_fw_raddr      (w_fw_raddr),
        .o_lane_raddr    (w_lane_raddr),
        .o_acc_we        (w_acc_we),
        .o_acc_waddr     (w_acc_waddr),
        .o_ctl           (w_ctl),
        .o_finish        (w_finish)
    );

    nnae_store #(
        .FEATURES (FEATURES),
        .HIDDEN   (HIDDEN)
    ) u_store (
        .i_clk        (i_clk),
        .i_value      (i_value),
        .i_fw_we      (w_fw_we),
        .i_fw_waddr   (w_fw_waddr),
        .i_fw_raddr   (w_fw_raddr),
        .i_nb_we      (w_nb_we),
        .i_ow_we      (w_ow_we),
        .i_hw_waddr   (w_hw_waddr),
        .i_lane_raddr (w_lane_raddr),
        .i_acc_we     (w_acc_we),
        .i_acc_waddr  (w_acc_waddr),
        .i_acc_wdata  (w_lane),
        .o_fw_rdata   (w_fw_rdata),
        .o_nb_rdata   (w_nb_rdata),
        .o_ow_rdata   (w_ow_rdata),
        .o_acc_rdata  (w_acc_rdata)
    );

    nnae_lane_unit u_lane (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_bias (w_output_bias),
        .i_acc  (w_acc_rdata),
        .i_in_w (w_fw_rdata),
        .i_nb   (w_nb_rdata),
        .i_ow   (w_ow_rdata),
        .o_lane (w_lane),
        .o_sum  (w_sum)
    );

    // round toward zero: bias negative sums up before the arithmetic shift
    assign w_adj = w_sum + (w_sum[SUM_W-1] ? ROUND_ADJ : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_score <= w_adj[SUM_W-1:DIV_SHIFT];
        end
    end

    assign o_valid = r_valid;
    assign o_score = r_score;

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start transaction");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result presented while still busy");

    a_acc_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_we |-> busy)
        else $error("accumulator written outside an operation");

endmodule
